FILE: rtl/iwer_pkg.sv
// Shared types and constants of the isometric wireframe edge rasterizer.
package iwer_pkg;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_ANGLE_H    = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ANGLE_V    = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZOOM       = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT_SC  = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_H   = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_V   = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_W     = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_H     = 4'd7;

    localparam logic signed [15:0] RST_ANGLE_H   = 16'sd13107;
    localparam logic signed [15:0] RST_ANGLE_V   = 16'sd6554;
    localparam logic [7:0]         RST_ZOOM      = 8'd20;
    localparam logic signed [15:0] RST_HEIGHT_SC = 16'sd256;
    localparam logic [10:0]        RST_GRID      = 11'd2;

    localparam logic [7:0] ALPHA_BASE      = 8'h7F;
    localparam int         BYTES_PER_PIXEL = 4;
    localparam int         QUEUE_DEPTH     = 2;

    typedef struct packed {
        logic               action;
        logic [9:0]         grid_col;
        logic [9:0]         grid_row;
        logic               direction;
        logic signed [15:0] height_start;
        logic signed [15:0] height_end;
        logic [7:0]         base_red;
        logic [7:0]         base_green;
        logic [7:0]         base_blue;
    } item_t;

    typedef struct packed {
        logic        write_enable;
        logic [9:0]  pixel_x;
        logic [9:0]  pixel_y;
        logic [21:0] byte_address;
        logic [7:0]  chan_first;
        logic [7:0]  chan_second;
        logic [7:0]  chan_third;
        logic [7:0]  chan_alpha;
        logic        last;
    } result_t;

    typedef struct packed {
        logic signed [15:0] angle_horizontal;
        logic signed [15:0] angle_vertical;
        logic [7:0]         zoom_factor;
        logic signed [15:0] height_scale;
        logic signed [12:0] offset_horizontal;
        logic signed [12:0] offset_vertical;
        logic [10:0]        grid_width;
        logic [10:0]        grid_height;
    } cfg_t;

    typedef struct packed {
        logic [31:0] pos_horizontal;
        logic [31:0] pos_vertical;
        logic [31:0] step_horizontal;
        logic [31:0] step_vertical;
        logic [31:0] remaining_length;
        logic [23:0] edge_color;
    } setup_res_t;

    typedef struct packed {
        logic ready;
        logic done;
    } setup_stat_t;

    typedef enum logic [3:0] {
        SU_IDLE,
        SU_MUL,
        SU_ZOOM,
        SU_POS,
        SU_DIFF,
        SU_SQUARE,
        SU_SUM,
        SU_ROOT,
        SU_DIV,
        SU_DONE
    } su_state_t;

endpackage

FILE: rtl/iwer_fifo.sv
// Small first-in first-out queue used on the input and result sides.
module iwer_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/iwer_setup.sv
// Edge setup engine: projection, iterative square root and step divisions.
module iwer_setup #(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 768,
    parameter int FRAC_BITS     = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  iwer_pkg::cfg_t       cfg,
    input  logic                 start,
    input  iwer_pkg::item_t      start_item,
    output iwer_pkg::setup_stat_t stat,
    output iwer_pkg::setup_res_t res
);

    localparam int NUM_W = 31 + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int SHL   = (FRAC_BITS >= 16) ? (FRAC_BITS - 16) : 0;
    localparam int SHR   = (FRAC_BITS < 16) ? (16 - FRAC_BITS) : 0;
    localparam logic signed [59:0] BASE_H  = 60'(SCREEN_WIDTH / 2);
    localparam logic signed [59:0] BASE_V  = 60'(SCREEN_HEIGHT / 2);
    localparam logic signed [59:0] POS_MAX = 60'sd1073741823;
    localparam logic signed [59:0] POS_MIN = -60'sd1073741824;

    function automatic logic [31:0] to_pos(input logic signed [41:0] raw,
                                           input logic signed [12:0] off,
                                           input logic signed [59:0] base);
        logic signed [59:0] ext;
        logic signed [59:0] r;
        ext = 60'(raw);
        if (FRAC_BITS >= 16)
        begin
            r = ext <<< SHL;
        end
        else
        begin
            r = ext >>> SHR;
        end
        r = r + ((base + 60'(off)) <<< FRAC_BITS);
        if (r > POS_MAX)
        begin
            r = POS_MAX;
        end
        else if (r < POS_MIN)
        begin
            r = POS_MIN;
        end
        return r[31:0];
    endfunction

    iwer_pkg::su_state_t state_reg;
    iwer_pkg::su_state_t state_next;

    logic [CNT_W-1:0]   cnt_reg;
    logic signed [12:0] a0_reg, a1_reg, b0_reg, b1_reg;
    logic signed [15:0] h0_reg, h1_reg;
    logic [23:0]        color_reg;
    logic signed [28:0] pa0_reg, pa1_reg, pb0_reg, pb1_reg;
    logic signed [31:0] ph0_reg, ph1_reg;
    logic signed [37:0] za0_reg, za1_reg, zb0_reg, zb1_reg;
    logic [31:0]        x0_reg, y0_reg, x1_reg, y1_reg;
    logic [31:0]        adx_reg, ady_reg;
    logic               negx_reg, negy_reg;
    logic [63:0]        sqx_reg, sqy_reg;
    logic [63:0]        sq_v_reg;
    logic [33:0]        sq_rem_reg;
    logic [31:0]        sq_root_reg;
    logic [NUM_W-1:0]   numx_reg, numy_reg;
    logic [NUM_W-1:0]   qx_reg, qy_reg;
    logic [31:0]        dvx_rem_reg, dvy_rem_reg;

    logic signed [11:0] yt, zt;
    logic signed [32:0] dx, dy;
    logic [35:0]        rt_rem_t, rt_trial;
    logic               rt_ge;
    logic [31:0]        rt_root_new;
    logic [32:0]        dvx_t, dvy_t;
    logic               dvx_ge, dvy_ge;

    always_comb
    begin
        yt = $signed({2'b00, start_item.grid_col}) - $signed({2'b00, cfg.grid_width[10:1]});
        zt = $signed({2'b00, start_item.grid_row}) - $signed({2'b00, cfg.grid_height[10:1]});
        dx = 33'(signed'(x1_reg)) - 33'(signed'(x0_reg));
        dy = 33'(signed'(y1_reg)) - 33'(signed'(y0_reg));
        rt_rem_t    = {sq_rem_reg, sq_v_reg[63:62]};
        rt_trial    = {2'b00, sq_root_reg, 2'b01};
        rt_ge       = (rt_rem_t >= rt_trial);
        rt_root_new = {sq_root_reg[30:0], rt_ge};
        dvx_t  = {dvx_rem_reg, numx_reg[NUM_W-1]};
        dvy_t  = {dvy_rem_reg, numy_reg[NUM_W-1]};
        dvx_ge = (dvx_t >= {1'b0, sq_root_reg});
        dvy_ge = (dvy_t >= {1'b0, sq_root_reg});
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            iwer_pkg::SU_IDLE:   if (start) state_next = iwer_pkg::SU_MUL;
            iwer_pkg::SU_MUL:    state_next = iwer_pkg::SU_ZOOM;
            iwer_pkg::SU_ZOOM:   state_next = iwer_pkg::SU_POS;
            iwer_pkg::SU_POS:    state_next = iwer_pkg::SU_DIFF;
            iwer_pkg::SU_DIFF:   state_next = iwer_pkg::SU_SQUARE;
            iwer_pkg::SU_SQUARE: state_next = iwer_pkg::SU_SUM;
            iwer_pkg::SU_SUM:    state_next = iwer_pkg::SU_ROOT;
            iwer_pkg::SU_ROOT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = (rt_root_new == '0) ? iwer_pkg::SU_DONE : iwer_pkg::SU_DIV;
                end
            end
            iwer_pkg::SU_DIV:    if (cnt_reg == '0) state_next = iwer_pkg::SU_DONE;
            iwer_pkg::SU_DONE:   state_next = iwer_pkg::SU_IDLE;
            default:             state_next = iwer_pkg::SU_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= iwer_pkg::SU_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == iwer_pkg::SU_SUM)
            begin
                cnt_reg <= CNT_W'(31);
            end
            else if (state_reg == iwer_pkg::SU_ROOT && cnt_reg == '0)
            begin
                cnt_reg <= CNT_W'(NUM_W - 1);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            iwer_pkg::SU_IDLE:
            begin
                a0_reg    <= 13'(yt) - 13'(zt);
                a1_reg    <= start_item.direction ? (13'(yt) - 13'(zt) - 13'sd1)
                                                  : (13'(yt) - 13'(zt) + 13'sd1);
                b0_reg    <= 13'(yt) + 13'(zt);
                b1_reg    <= 13'(yt) + 13'(zt) + 13'sd1;
                h0_reg    <= start_item.height_start;
                h1_reg    <= start_item.height_end;
                color_reg <= {start_item.base_red, start_item.base_green, start_item.base_blue};
            end
            iwer_pkg::SU_MUL:
            begin
                pa0_reg <= cfg.angle_horizontal * a0_reg;
                pa1_reg <= cfg.angle_horizontal * a1_reg;
                pb0_reg <= cfg.angle_vertical * b0_reg;
                pb1_reg <= cfg.angle_vertical * b1_reg;
                ph0_reg <= h0_reg * cfg.height_scale;
                ph1_reg <= h1_reg * cfg.height_scale;
            end
            iwer_pkg::SU_ZOOM:
            begin
                za0_reg <= pa0_reg * $signed({1'b0, cfg.zoom_factor});
                za1_reg <= pa1_reg * $signed({1'b0, cfg.zoom_factor});
                zb0_reg <= pb0_reg * $signed({1'b0, cfg.zoom_factor});
                zb1_reg <= pb1_reg * $signed({1'b0, cfg.zoom_factor});
            end
            iwer_pkg::SU_POS:
            begin
                x0_reg <= to_pos(42'(za0_reg) <<< 2, cfg.offset_horizontal, BASE_H);
                x1_reg <= to_pos(42'(za1_reg) <<< 2, cfg.offset_horizontal, BASE_H);
                y0_reg <= to_pos((42'(zb0_reg) <<< 2) - (42'(ph0_reg) <<< 8),
                                 cfg.offset_vertical, BASE_V);
                y1_reg <= to_pos((42'(zb1_reg) <<< 2) - (42'(ph1_reg) <<< 8),
                                 cfg.offset_vertical, BASE_V);
            end
            iwer_pkg::SU_DIFF:
            begin
                negx_reg <= dx[32];
                negy_reg <= dy[32];
                adx_reg  <= dx[32] ? 32'(-dx) : dx[31:0];
                ady_reg  <= dy[32] ? 32'(-dy) : dy[31:0];
            end
            iwer_pkg::SU_SQUARE:
            begin
                sqx_reg <= 64'(adx_reg) * 64'(adx_reg);
                sqy_reg <= 64'(ady_reg) * 64'(ady_reg);
            end
            iwer_pkg::SU_SUM:
            begin
                sq_v_reg    <= sqx_reg + sqy_reg;
                sq_rem_reg  <= '0;
                sq_root_reg <= '0;
            end
            iwer_pkg::SU_ROOT:
            begin
                sq_v_reg    <= {sq_v_reg[61:0], 2'b00};
                sq_rem_reg  <= rt_ge ? 34'(rt_rem_t - rt_trial) : rt_rem_t[33:0];
                sq_root_reg <= rt_root_new;
                numx_reg    <= NUM_W'(adx_reg) << FRAC_BITS;
                numy_reg    <= NUM_W'(ady_reg) << FRAC_BITS;
                dvx_rem_reg <= '0;
                dvy_rem_reg <= '0;
            end
            iwer_pkg::SU_DIV:
            begin
                numx_reg    <= {numx_reg[NUM_W-2:0], 1'b0};
                numy_reg    <= {numy_reg[NUM_W-2:0], 1'b0};
                dvx_rem_reg <= dvx_ge ? 32'(dvx_t - {1'b0, sq_root_reg}) : dvx_t[31:0];
                dvy_rem_reg <= dvy_ge ? 32'(dvy_t - {1'b0, sq_root_reg}) : dvy_t[31:0];
                qx_reg      <= {qx_reg[NUM_W-2:0], dvx_ge};
                qy_reg      <= {qy_reg[NUM_W-2:0], dvy_ge};
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        stat.ready = (state_reg == iwer_pkg::SU_IDLE);
        stat.done  = (state_reg == iwer_pkg::SU_DONE);
        res.pos_horizontal   = x0_reg;
        res.pos_vertical     = y0_reg;
        res.remaining_length = sq_root_reg;
        res.edge_color       = color_reg;
        if (sq_root_reg == '0)
        begin
            res.step_horizontal = '0;
            res.step_vertical   = '0;
        end
        else
        begin
            res.step_horizontal = negx_reg ? (32'd0 - qx_reg[31:0]) : qx_reg[31:0];
            res.step_vertical   = negy_reg ? (32'd0 - qy_reg[31:0]) : qy_reg[31:0];
        end
    end

endmodule

FILE: rtl/iwer_stepper.sv
// Dispatch of queued items and the per-step line walker that forms pixels.
module iwer_stepper #(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 768,
    parameter int FRAC_BITS     = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  iwer_pkg::item_t       head,
    output logic                  head_pop,
    input  iwer_pkg::setup_stat_t su_stat,
    input  iwer_pkg::setup_res_t  su_res,
    output logic                  su_start,
    input  logic                  out_full,
    output logic                  out_push,
    output iwer_pkg::result_t     out_item
);

    localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

    logic [31:0] pos_h_reg, pos_v_reg, step_h_reg, step_v_reg, rem_reg;
    logic [23:0] color_reg;

    logic        is_step;
    logic        emit;
    logic        drop;
    logic        fin;
    logic        vis;
    logic [32:0] ix_w, iy_w;
    logic [7:0]  ip;

    always_comb
    begin
        is_step  = (head.action == iwer_pkg::ACT_STEP);
        su_start = head_valid && !is_step && su_stat.ready;
        emit     = head_valid && is_step && su_stat.ready && (rem_reg != '0) && !out_full;
        drop     = head_valid && is_step && su_stat.ready && (rem_reg == '0);
        head_pop = su_start || emit || drop;
        out_push = emit;

        ix_w = 33'(pos_h_reg[31:FRAC_BITS]);
        iy_w = 33'(pos_v_reg[31:FRAC_BITS]);
        vis  = !pos_h_reg[31] && !pos_v_reg[31] && (ix_w != '0) && (iy_w != '0)
               && (ix_w < 33'(SCREEN_WIDTH)) && (iy_w < 33'(SCREEN_HEIGHT));
        fin  = (rem_reg <= ONE);
        ip   = rem_reg[FRAC_BITS+7:FRAC_BITS];

        out_item.write_enable = vis;
        out_item.pixel_x      = vis ? ix_w[9:0] : '0;
        out_item.pixel_y      = vis ? iy_w[9:0] : '0;
        out_item.byte_address = vis ? 22'((ix_w[21:0] << 2)
                                          + iy_w[21:0] * 22'(SCREEN_WIDTH
                                                             * iwer_pkg::BYTES_PER_PIXEL))
                                    : '0;
        out_item.chan_first   = color_reg[23:16] + ip;
        out_item.chan_second  = color_reg[15:8] + ip;
        out_item.chan_third   = color_reg[7:0] + ip;
        out_item.chan_alpha   = iwer_pkg::ALPHA_BASE + ip;
        out_item.last         = fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_h_reg  <= '0;
            pos_v_reg  <= '0;
            step_h_reg <= '0;
            step_v_reg <= '0;
            rem_reg    <= '0;
            color_reg  <= '0;
        end
        else if (su_stat.done)
        begin
            pos_h_reg  <= su_res.pos_horizontal;
            pos_v_reg  <= su_res.pos_vertical;
            step_h_reg <= su_res.step_horizontal;
            step_v_reg <= su_res.step_vertical;
            rem_reg    <= su_res.remaining_length;
            color_reg  <= su_res.edge_color;
        end
        else if (emit)
        begin
            pos_h_reg <= pos_h_reg + step_h_reg;
            pos_v_reg <= pos_v_reg + step_v_reg;
            rem_reg   <= fin ? '0 : rem_reg - ONE;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) out_push |-> !out_full)
        else $error("result pushed into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n) out_push && out_item.last |=> rem_reg == '0)
        else $error("edge still active after its final pixel");

    assert property (@(posedge clk) disable iff (!rst_n) su_start |=> !su_stat.ready)
        else $error("setup did not take the start transaction");

    assert property (@(posedge clk) disable iff (!rst_n) su_stat.done |-> !head_pop)
        else $error("item dispatched while setup results load");

endmodule

FILE: rtl/isometric_wireframe_edge_rasterizer_top.sv
// Top level of the isometric wireframe edge rasterizer.
// Items enter a two-entry queue and results leave through another. A step item
// yields at most one pixel, so steps stream at one per cycle while results are
// popped and the setup engine is idle. A start item occupies the setup engine
// for the projection multiplies and sums, a bit-serial square root, the two
// bit-serial step dividers, which are skipped for a zero-length edge, and a
// final state that hands the results over. Configuration writes are taken
// in any cycle and are meant for idle times.
module isometric_wireframe_edge_rasterizer_top #(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 768,
    parameter int FRAC_BITS     = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  iwer_pkg::item_t                     item,
    output logic                                empty,
    input  logic                                pop,
    output iwer_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [iwer_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [iwer_pkg::CFG_DATA_W-1:0]     cfg_data
);

    iwer_pkg::cfg_t        cfg_reg;
    iwer_pkg::item_t       head;
    logic                  head_empty;
    logic                  head_pop;
    iwer_pkg::setup_stat_t su_stat;
    iwer_pkg::setup_res_t  su_res;
    logic                  su_start;
    logic                  out_full;
    logic                  out_push;
    iwer_pkg::result_t     out_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angle_horizontal  <= iwer_pkg::RST_ANGLE_H;
            cfg_reg.angle_vertical    <= iwer_pkg::RST_ANGLE_V;
            cfg_reg.zoom_factor       <= iwer_pkg::RST_ZOOM;
            cfg_reg.height_scale      <= iwer_pkg::RST_HEIGHT_SC;
            cfg_reg.offset_horizontal <= '0;
            cfg_reg.offset_vertical   <= '0;
            cfg_reg.grid_width        <= iwer_pkg::RST_GRID;
            cfg_reg.grid_height       <= iwer_pkg::RST_GRID;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                iwer_pkg::CFG_ANGLE_H:   cfg_reg.angle_horizontal  <= cfg_data;
                iwer_pkg::CFG_ANGLE_V:   cfg_reg.angle_vertical    <= cfg_data;
                iwer_pkg::CFG_ZOOM:      cfg_reg.zoom_factor       <= cfg_data[7:0];
                iwer_pkg::CFG_HEIGHT_SC: cfg_reg.height_scale      <= cfg_data;
                iwer_pkg::CFG_OFFSET_H:  cfg_reg.offset_horizontal <= cfg_data[12:0];
                iwer_pkg::CFG_OFFSET_V:  cfg_reg.offset_vertical   <= cfg_data[12:0];
                iwer_pkg::CFG_GRID_W:    cfg_reg.grid_width        <= cfg_data[10:0];
                iwer_pkg::CFG_GRID_H:    cfg_reg.grid_height       <= cfg_data[10:0];
                default:
                begin
                end
            endcase
        end
    end

    iwer_fifo #(
        .WIDTH ($bits(iwer_pkg::item_t)),
        .DEPTH (iwer_pkg::QUEUE_DEPTH)
    ) u_in_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (item),
        .full  (full),
        .pop   (head_pop),
        .dout  (head),
        .empty (head_empty)
    );

    iwer_setup #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .FRAC_BITS     (FRAC_BITS)
    ) u_setup (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .start      (su_start),
        .start_item (head),
        .stat       (su_stat),
        .res        (su_res)
    );

    iwer_stepper #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .FRAC_BITS     (FRAC_BITS)
    ) u_stepper (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (!head_empty),
        .head       (head),
        .head_pop   (head_pop),
        .su_stat    (su_stat),
        .su_res     (su_res),
        .su_start   (su_start),
        .out_full   (out_full),
        .out_push   (out_push),
        .out_item   (out_item)
    );

    iwer_fifo #(
        .WIDTH ($bits(iwer_pkg::result_t)),
        .DEPTH (iwer_pkg::QUEUE_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .din   (out_item),
        .full  (out_full),
        .pop   (pop),
        .dout  (result),
        .empty (empty)
    );

endmodule
